>>> sv/srsw_pkg.sv
// Shared types and constants for the selective-repeat sender window.
// Used by the channel interfaces and by every module of the block.
package srsw_pkg;

    localparam int SEQ_SPACE    = 8;
    localparam int SEQ_BITS     = $clog2(SEQ_SPACE);
    localparam int PAYLOAD_BITS = 32;
    localparam int WSIZE_BITS   = 3;
    localparam int QUEUE_DEPTH  = 2;
    localparam int QPTR_BITS    = $clog2(QUEUE_DEPTH);

    localparam logic [WSIZE_BITS-1:0] WSIZE_RESET = 3'd4;

    localparam logic [1:0] FUNC_SEND   = 2'd0;
    localparam logic [1:0] FUNC_ACK    = 2'd1;
    localparam logic [1:0] FUNC_EXPIRE = 2'd2;

    typedef enum logic [1:0] {
        CMD_SEND,
        CMD_ACK,
        CMD_EXPIRE,
        CMD_NOP
    } cmd_kind_t;

    typedef struct packed {
        cmd_kind_t                kind;
        logic [PAYLOAD_BITS-1:0]  payload;
        logic [SEQ_BITS-1:0]      seq;
        logic                     ack_ok;
    } cmd_t;

    typedef struct packed {
        logic                     accepted;
        logic                     transmit;
        logic [SEQ_BITS-1:0]      tx_seq;
        logic [PAYLOAD_BITS-1:0]  tx_payload;
        logic                     timer_start;
        logic                     timer_stop;
        logic [SEQ_BITS-1:0]      timer_slot;
        logic                     window_full;
        logic [SEQ_BITS-1:0]      window_base;
    } rsp_t;

endpackage

>>> sv/srsw_ifs.sv
// Valid/ready channel interfaces: request, response and config write.
// Depends on srsw_pkg for widths.
interface srsw_req_if;
    logic                               valid;
    logic                               ready;
    logic [1:0]                         func;
    logic [srsw_pkg::PAYLOAD_BITS-1:0]  payload_word;
    logic [srsw_pkg::SEQ_BITS-1:0]      ack_number;
    logic                               ack_checksum_ok;
    logic [srsw_pkg::SEQ_BITS-1:0]      expired_seq;

    modport source (output valid, func, payload_word, ack_number, ack_checksum_ok,
                    expired_seq, input ready);
    modport sink   (input valid, func, payload_word, ack_number, ack_checksum_ok,
                    expired_seq, output ready);
endinterface

interface srsw_rsp_if;
    logic                               valid;
    logic                               ready;
    logic                               accepted;
    logic                               transmit;
    logic [srsw_pkg::SEQ_BITS-1:0]      tx_seq;
    logic [srsw_pkg::PAYLOAD_BITS-1:0]  tx_payload;
    logic                               timer_start;
    logic                               timer_stop;
    logic [srsw_pkg::SEQ_BITS-1:0]      timer_slot;
    logic                               window_full;
    logic [srsw_pkg::SEQ_BITS-1:0]      window_base;

    modport source (output valid, accepted, transmit, tx_seq, tx_payload, timer_start,
                    timer_stop, timer_slot, window_full, window_base, input ready);
    modport sink   (input valid, accepted, transmit, tx_seq, tx_payload, timer_start,
                    timer_stop, timer_slot, window_full, window_base, output ready);
endinterface

interface srsw_cfg_if;
    logic                               valid;
    logic                               ready;
    logic [srsw_pkg::WSIZE_BITS-1:0]    data;

    modport source (output valid, data, input ready);
    modport sink   (input valid, data, output ready);
endinterface

>>> sv/selective_repeat_sender_window_unit.sv
// Selective-repeat sender window: one response word for each request word.
// A request enters a two-deep command queue and the back end handles it: a send,
// an ack off the window base, an invalid ack or an unknown code is answered from
// idle; a timer expiry first reads the stored payload from a registered memory port
// in ST_READ; an ack to the base walks the base past each acked slot in ST_SLIDE.
// The response sits in an output register, so the queue keeps taking requests while
// a response waits. Window size is to be written through cfg by the user only while
// the block is idle; the block does not enforce it. It resets to 4.
module selective_repeat_sender_window_unit (
    input  logic        clk,
    input  logic        rst_n,
    srsw_req_if.sink    req,
    srsw_rsp_if.source  rsp,
    srsw_cfg_if.sink    cfg
);

    logic               push_valid, push_ready;
    srsw_pkg::cmd_t     push_cmd;
    logic               cmd_valid, cmd_ready;
    srsw_pkg::cmd_t     cmd;

    srsw_front u_front (
        .req        (req),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready)
    );

    srsw_cmd_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push_valid (push_valid),
        .push_cmd   (push_cmd),
        .push_ready (push_ready),
        .pop_valid  (cmd_valid),
        .pop_cmd    (cmd),
        .pop_ready  (cmd_ready)
    );

    srsw_back u_back (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg        (cfg),
        .cmd_valid  (cmd_valid),
        .cmd        (cmd),
        .cmd_ready  (cmd_ready),
        .rsp        (rsp)
    );

    // a transmit always restarts the timer of the slot that goes out
    a_tx_timer: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.transmit |->
            rsp.timer_start && !rsp.timer_stop && (rsp.timer_slot == rsp.tx_seq))
        else $error("transmit without matching timer start");

    // a timer stop only comes from an accepted ack
    a_stop_ack: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.timer_stop |-> rsp.accepted && !rsp.transmit)
        else $error("timer stop on a non-ack response");

    // the back end only takes a command it can answer into a free output register
    a_pop_free: assert property (@(posedge clk) disable iff (!rst_n)
        cmd_valid && cmd_ready |-> !rsp.valid || rsp.ready)
        else $error("command taken while response register busy");

endmodule

>>> sv/srsw_front.sv
// Front end: takes request words and decodes them into queue commands.
// Depends on srsw_pkg and srsw_req_if.
module srsw_front (
    srsw_req_if.sink            req,
    output logic                push_valid,
    output srsw_pkg::cmd_t      push_cmd,
    input  logic                push_ready
);

    always_comb
    begin
        push_cmd.payload = req.payload_word;
        push_cmd.ack_ok  = req.ack_checksum_ok;
        push_cmd.seq     = req.ack_number;
        case (req.func)
            srsw_pkg::FUNC_SEND:   push_cmd.kind = srsw_pkg::CMD_SEND;
            srsw_pkg::FUNC_ACK:    push_cmd.kind = srsw_pkg::CMD_ACK;
            srsw_pkg::FUNC_EXPIRE:
            begin
                push_cmd.kind = srsw_pkg::CMD_EXPIRE;
                push_cmd.seq  = req.expired_seq;
            end
            default:               push_cmd.kind = srsw_pkg::CMD_NOP;
        endcase
    end

    assign push_valid = req.valid;
    assign req.ready  = push_ready;

endmodule

>>> sv/srsw_cmd_queue.sv
// Short command queue between front end and back end.
// Depends on srsw_pkg for the command type and depth.
module srsw_cmd_queue (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                push_valid,
    input  srsw_pkg::cmd_t      push_cmd,
    output logic                push_ready,
    output logic                pop_valid,
    output srsw_pkg::cmd_t      pop_cmd,
    input  logic                pop_ready
);

    localparam int CNT_BITS = $clog2(srsw_pkg::QUEUE_DEPTH + 1);

    srsw_pkg::cmd_t                     entry_reg [srsw_pkg::QUEUE_DEPTH];
    logic [srsw_pkg::QPTR_BITS-1:0]     wr_ptr_reg, wr_ptr_next;
    logic [srsw_pkg::QPTR_BITS-1:0]     rd_ptr_reg, rd_ptr_next;
    logic [CNT_BITS-1:0]                count_reg, count_next;
    logic                               do_push, do_pop;

    assign push_ready = (count_reg != CNT_BITS'(srsw_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_cmd    = entry_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push)
        begin
            wr_ptr_next = (wr_ptr_reg == srsw_pkg::QPTR_BITS'(srsw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop)
        begin
            rd_ptr_next = (rd_ptr_reg == srsw_pkg::QPTR_BITS'(srsw_pkg::QUEUE_DEPTH - 1))
                          ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop)
            count_next = count_reg + 1'b1;
        else if (do_pop && !do_push)
            count_next = count_reg - 1'b1;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            entry_reg[wr_ptr_reg] <= push_cmd;
    end

endmodule

>>> sv/srsw_back.sv
// Back end: window state, payload store, base slide walk and result register.
// Depends on srsw_pkg, srsw_cfg_if and srsw_rsp_if.
module srsw_back (
    input  logic                clk,
    input  logic                rst_n,
    srsw_cfg_if.sink            cfg,
    input  logic                cmd_valid,
    input  srsw_pkg::cmd_t      cmd,
    output logic                cmd_ready,
    srsw_rsp_if.source          rsp
);

    localparam int SB = srsw_pkg::SEQ_BITS;
    localparam int PB = srsw_pkg::PAYLOAD_BITS;

    typedef enum logic [2:0] {
        ST_IDLE  = 3'b001,
        ST_READ  = 3'b010,
        ST_SLIDE = 3'b100
    } state_t;

    state_t                             state_reg, state_next;
    logic [srsw_pkg::WSIZE_BITS-1:0]    wsize_reg;
    logic [SB-1:0]                      base_reg, base_next;
    logic [SB-1:0]                      next_reg, next_next;
    logic                               full_reg, full_next;
    logic [srsw_pkg::SEQ_SPACE-1:0]     acked_reg, acked_next;
    logic [SB-1:0]                      seq_reg, seq_next;
    logic [PB-1:0]                      payload_mem [srsw_pkg::SEQ_SPACE];
    logic [PB-1:0]                      rdata_reg;
    srsw_pkg::rsp_t                     res_reg, res_next;
    logic                               out_valid_reg, out_valid_next;

    logic                               out_free, start, load, mem_we;
    logic [SB-1:0]                      next_inc;
    logic                               send_full, ack_in_window;

    assign out_free      = !out_valid_reg || rsp.ready;
    assign start         = (state_reg == ST_IDLE) && cmd_valid && out_free;
    assign cmd_ready     = start;
    assign cfg.ready     = 1'b1;
    assign next_inc      = next_reg + 1'b1;
    // distances are taken modulo the sequence space by 3-bit wraparound
    assign send_full     = SB'(next_inc - base_reg) >= SB'(wsize_reg);
    assign ack_in_window = cmd.ack_ok &&
                           (SB'(cmd.seq - base_reg) < SB'(next_reg - base_reg));

    always_comb
    begin
        state_next = state_reg;
        base_next  = base_reg;
        next_next  = next_reg;
        full_next  = full_reg;
        acked_next = acked_reg;
        seq_next   = seq_reg;
        mem_we     = 1'b0;
        load       = 1'b0;
        res_next   = '0;
        res_next.window_full = full_reg;
        res_next.window_base = base_reg;

        case (state_reg)
            ST_IDLE:
            begin
                if (start)
                begin
                    case (cmd.kind)
                        srsw_pkg::CMD_SEND:
                        begin
                            load = 1'b1;
                            if (!full_reg)
                            begin
                                mem_we                = 1'b1;
                                acked_next[next_reg]  = 1'b0;
                                next_next             = next_inc;
                                full_next             = send_full;
                                res_next.accepted     = 1'b1;
                                res_next.transmit     = 1'b1;
                                res_next.tx_seq       = next_reg;
                                res_next.tx_payload   = cmd.payload;
                                res_next.timer_start  = 1'b1;
                                res_next.timer_slot   = next_reg;
                                res_next.window_full  = send_full;
                            end
                        end
                        srsw_pkg::CMD_ACK:
                        begin
                            if (ack_in_window)
                            begin
                                acked_next[cmd.seq] = 1'b1;
                                if (cmd.seq == base_reg)
                                begin
                                    seq_next   = cmd.seq;
                                    state_next = ST_SLIDE;
                                end
                                else
                                begin
                                    load                = 1'b1;
                                    res_next.accepted   = 1'b1;
                                    res_next.timer_stop = 1'b1;
                                    res_next.timer_slot = cmd.seq;
                                end
                            end
                            else
                            begin
                                load = 1'b1;
                            end
                        end
                        srsw_pkg::CMD_EXPIRE:
                        begin
                            seq_next   = cmd.seq;
                            state_next = ST_READ;
                        end
                        default:
                        begin
                            load = 1'b1;
                        end
                    endcase
                end
            end
            ST_READ:
            begin
                load                 = 1'b1;
                res_next.transmit    = 1'b1;
                res_next.tx_seq      = seq_reg;
                res_next.tx_payload  = rdata_reg;
                res_next.timer_start = 1'b1;
                res_next.timer_slot  = seq_reg;
                state_next           = ST_IDLE;
            end
            ST_SLIDE:
            begin
                // one acked mark per cycle; the walk stops at the first unacked slot
                if (acked_reg[base_reg])
                begin
                    acked_next[base_reg] = 1'b0;
                    base_next            = base_reg + 1'b1;
                end
                else
                begin
                    load                 = 1'b1;
                    full_next            = 1'b0;
                    res_next.accepted    = 1'b1;
                    res_next.timer_stop  = 1'b1;
                    res_next.timer_slot  = seq_reg;
                    res_next.window_full = 1'b0;
                    state_next           = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (load)
            out_valid_next = 1'b1;
        else if (rsp.ready)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            wsize_reg     <= srsw_pkg::WSIZE_RESET;
            base_reg      <= '0;
            next_reg      <= '0;
            full_reg      <= 1'b0;
            acked_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            base_reg      <= base_next;
            next_reg      <= next_next;
            full_reg      <= full_next;
            acked_reg     <= acked_next;
            out_valid_reg <= out_valid_next;
            if (cfg.valid)
                wsize_reg <= cfg.data;
        end
    end

    always_ff @(posedge clk)
    begin
        seq_reg <= seq_next;
        if (load)
            res_reg <= res_next;
        if (mem_we)
            payload_mem[next_reg] <= cmd.payload;
        if (start && (cmd.kind == srsw_pkg::CMD_EXPIRE))
            rdata_reg <= payload_mem[cmd.seq];
    end

    assign rsp.valid       = out_valid_reg;
    assign rsp.accepted    = res_reg.accepted;
    assign rsp.transmit    = res_reg.transmit;
    assign rsp.tx_seq      = res_reg.tx_seq;
    assign rsp.tx_payload  = res_reg.tx_payload;
    assign rsp.timer_start = res_reg.timer_start;
    assign rsp.timer_stop  = res_reg.timer_stop;
    assign rsp.timer_slot  = res_reg.timer_slot;
    assign rsp.window_full = res_reg.window_full;
    assign rsp.window_base = res_reg.window_base;

endmodule

>>> tb/srsw_window_monitor.sv
// Watches the request, response and window-size channels of the sender window,
// predicts each response word and compares it field by field.
// Depends on srsw_pkg and the channel interfaces in srsw_ifs.
module srsw_window_monitor (
    input  logic        clk,
    input  logic        rst_n,
    srsw_req_if         req,
    srsw_rsp_if         rsp,
    srsw_cfg_if         cfg,
    output int unsigned fail_count,
    output int unsigned words_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    import srsw_pkg::*;

    logic [WSIZE_BITS-1:0]   win_size;
    logic [SEQ_BITS-1:0]     base_seq;
    logic [SEQ_BITS-1:0]     next_seq;
    logic                    full_q;
    logic [SEQ_SPACE-1:0]    acked;
    logic [PAYLOAD_BITS-1:0] sent_payload [SEQ_SPACE];
    rsp_t                    due_responses [$];

    task automatic advance_window(
        input  logic [1:0]              func,
        input  logic [PAYLOAD_BITS-1:0] word,
        input  logic [SEQ_BITS-1:0]     ack_no,
        input  logic                    ack_ok,
        input  logic [SEQ_BITS-1:0]     lapsed,
        output rsp_t                    r
    );
        int walked;
        r = '0;
        case (func)
            FUNC_SEND:
                if (!full_q)
                begin
                    sent_payload[next_seq] = word;
                    acked[next_seq]        = 1'b0;
                    r.accepted    = 1'b1;
                    r.transmit    = 1'b1;
                    r.tx_seq      = next_seq;
                    r.tx_payload  = word;
                    r.timer_start = 1'b1;
                    r.timer_slot  = next_seq;
                    next_seq = next_seq + 1'b1;
                    // size 0 fills like size 1; 7 is already the largest the space allows
                    if (SEQ_BITS'(next_seq - base_seq) >= win_size)
                        full_q = 1'b1;
                end
            FUNC_ACK:
                if (ack_ok && SEQ_BITS'(ack_no - base_seq) < SEQ_BITS'(next_seq - base_seq))
                begin
                    r.accepted   = 1'b1;
                    r.timer_stop = 1'b1;
                    r.timer_slot = ack_no;
                    acked[ack_no] = 1'b1;
                    if (ack_no == base_seq)
                    begin
                        for (walked = 0; walked < SEQ_SPACE && acked[base_seq]; walked++)
                        begin
                            acked[base_seq] = 1'b0;
                            base_seq = base_seq + 1'b1;
                        end
                        full_q = 1'b0;
                    end
                end
            FUNC_EXPIRE:
            begin
                // timers live outside, so any slot may be resent
                r.transmit    = 1'b1;
                r.tx_seq      = lapsed;
                r.tx_payload  = sent_payload[lapsed];
                r.timer_start = 1'b1;
                r.timer_slot  = lapsed;
            end
            default:
            begin
            end
        endcase
        r.window_full = full_q;
        r.window_base = base_seq;
    endtask

    task automatic compare_field(
        input string                   field,
        input logic [PAYLOAD_BITS-1:0] want,
        input logic [PAYLOAD_BITS-1:0] got
    );
        if (got !== want)
        begin
            $error("%s: expected 0x%0h, got 0x%0h", field, want, got);
            fail_count++;
        end
    endtask

    always @(posedge clk or negedge rst_n)
    begin
        rsp_t want;
        int   slot;
        if (!rst_n)
        begin
            win_size = WSIZE_RESET;
            base_seq = '0;
            next_seq = '0;
            full_q   = 1'b0;
            acked    = '0;
            for (slot = 0; slot < SEQ_SPACE; slot++)
                sent_payload[slot] = '0;
            due_responses.delete();
            words_pending = 0;
        end
        else
        begin
            if (rsp.valid && rsp.ready)
            begin
                if (due_responses.size() == 0)
                begin
                    $error("response word with no request outstanding");
                    fail_count++;
                end
                else
                begin
                    want = due_responses.pop_front();
                    compare_field("accepted",    want.accepted,    rsp.accepted);
                    compare_field("transmit",    want.transmit,    rsp.transmit);
                    compare_field("tx_seq",      want.tx_seq,      rsp.tx_seq);
                    compare_field("tx_payload",  want.tx_payload,  rsp.tx_payload);
                    compare_field("timer_start", want.timer_start, rsp.timer_start);
                    compare_field("timer_stop",  want.timer_stop,  rsp.timer_stop);
                    compare_field("timer_slot",  want.timer_slot,  rsp.timer_slot);
                    compare_field("window_full", want.window_full, rsp.window_full);
                    compare_field("window_base", want.window_base, rsp.window_base);
                end
            end
            if (cfg.valid && cfg.ready)
                win_size = cfg.data;
            if (req.valid && req.ready)
            begin
                advance_window(req.func, req.payload_word, req.ack_number,
                               req.ack_checksum_ok, req.expired_seq, want);
                due_responses.push_back(want);
            end
            words_pending = due_responses.size();
        end
    end

endmodule

>>> tb/selective_repeat_sender_window_unit_test.sv
// Top of the sender window test: clock, reset, request and window-size stimulus,
// response back-pressure and the verdict. Depends on srsw_pkg, the channel
// interfaces, srsw_window_monitor and selective_repeat_sender_window_unit.
module selective_repeat_sender_window_unit_test;
    timeunit 1ns;
    timeprecision 1ps;

    import srsw_pkg::*;

    localparam logic [1:0] FUNC_UNKNOWN     = 2'd3;
    localparam int         RANDOM_WORDS     = 1250;
    localparam int         PHASES           = 8;
    localparam int         LONG_HOLD_CYCLES = 120;
    localparam int         SETTLE_CYCLES    = 16;
    localparam logic [WSIZE_BITS-1:0] PHASE_SIZES [PHASES] =
        '{3'd7, 3'd1, 3'd0, 3'd5, 3'd2, 3'd6, 3'd3, 3'd4};

    logic clk = 1'b0;
    logic rst_n;

    srsw_req_if req_ch();
    srsw_rsp_if rsp_ch();
    srsw_cfg_if cfg_ch();

    int unsigned fail_count;
    int unsigned words_pending;

    int sender_gap_pct     = 0;
    int receiver_stall_pct = 0;
    int hold_asked         = 0;

    // loose view of the window, used only to aim acks and expiries
    logic [SEQ_BITS-1:0]  base_hint    = '0;
    logic [SEQ_BITS-1:0]  next_hint    = '0;
    logic [SEQ_SPACE-1:0] written_hint = '0;

    selective_repeat_sender_window_unit i_dut (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (req_ch),
        .rsp   (rsp_ch),
        .cfg   (cfg_ch)
    );

    srsw_window_monitor i_monitor (
        .clk           (clk),
        .rst_n         (rst_n),
        .req           (req_ch),
        .rsp           (rsp_ch),
        .cfg           (cfg_ch),
        .fail_count    (fail_count),
        .words_pending (words_pending)
    );

    always
    begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        if (rsp_ch.valid && rsp_ch.ready)
        begin
            base_hint <= rsp_ch.window_base;
            if (rsp_ch.accepted && rsp_ch.transmit)
            begin
                next_hint <= rsp_ch.tx_seq + 1'b1;
                written_hint[rsp_ch.tx_seq] <= 1'b1;
            end
        end
    end

    task automatic offer_word(
        input logic [1:0]              func,
        input logic [PAYLOAD_BITS-1:0] word,
        input logic [SEQ_BITS-1:0]     ack_no,
        input logic                    ack_ok,
        input logic [SEQ_BITS-1:0]     lapsed
    );
        while ($urandom_range(0, 99) < sender_gap_pct)
        begin
            req_ch.valid <= 1'b0;
            @(posedge clk);
        end
        req_ch.valid           <= 1'b1;
        req_ch.func            <= func;
        req_ch.payload_word    <= word;
        req_ch.ack_number      <= ack_no;
        req_ch.ack_checksum_ok <= ack_ok;
        req_ch.expired_seq     <= lapsed;
        @(negedge clk);
        while (!req_ch.ready)
            @(negedge clk);
        @(posedge clk);
    endtask

    task automatic write_window_size(input logic [WSIZE_BITS-1:0] size);
        cfg_ch.valid <= 1'b1;
        cfg_ch.data  <= size;
        @(negedge clk);
        while (!cfg_ch.ready)
            @(negedge clk);
        @(posedge clk);
        cfg_ch.valid <= 1'b0;
    endtask

    task automatic settle();
        req_ch.valid <= 1'b0;
        @(negedge clk);
        while (words_pending != 0)
            @(negedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    initial
    begin : response_side
        int hold_left;
        int hold_served;
        hold_left    = 0;
        hold_served  = 0;
        rsp_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (!rst_n)
                rsp_ch.ready <= 1'b0;
            else if (hold_served != hold_asked)
            begin
                hold_served++;
                hold_left = LONG_HOLD_CYCLES - 1;
                rsp_ch.ready <= 1'b0;
            end
            else if (hold_left > 0)
            begin
                hold_left--;
                rsp_ch.ready <= 1'b0;
            end
            else
                rsp_ch.ready <= ($urandom_range(0, 99) >= receiver_stall_pct);
        end
    end

    initial
    begin : stimulus
        int                      phase;
        int                      words_sent;
        int                      roll;
        logic [1:0]              func;
        logic [PAYLOAD_BITS-1:0] word;
        logic [SEQ_BITS-1:0]     ack_no;
        logic [SEQ_BITS-1:0]     lapsed;
        logic [SEQ_BITS-1:0]     span;
        logic                    ack_ok;

        rst_n                  = 1'b0;
        req_ch.valid           = 1'b0;
        req_ch.func            = FUNC_SEND;
        req_ch.payload_word    = '0;
        req_ch.ack_number      = '0;
        req_ch.ack_checksum_ok = 1'b0;
        req_ch.expired_seq     = '0;
        cfg_ch.valid           = 1'b0;
        cfg_ch.data            = '0;
        repeat (11) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        write_window_size(3'd3);
        offer_word(FUNC_SEND,    32'h0000_0000, 3'd0, 1'b0, 3'd0);
        offer_word(FUNC_SEND,    32'hFFFF_FFFF, 3'd0, 1'b0, 3'd0);
        offer_word(FUNC_SEND,    32'hA5A5_5A5A, 3'd0, 1'b0, 3'd0);
        offer_word(FUNC_SEND,    32'h1234_5678, 3'd0, 1'b0, 3'd0);  // window full
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd1, 1'b1, 3'd0);  // out of order
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd2, 1'b0, 3'd0);  // bad checksum
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd7, 1'b1, 3'd0);  // outside window
        offer_word(FUNC_EXPIRE,  32'h0000_0000, 3'd0, 1'b0, 3'd1);
        offer_word(FUNC_UNKNOWN, 32'hFFFF_FFFF, 3'd7, 1'b1, 3'd7);
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd0, 1'b1, 3'd0);  // base walks past 1
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd0, 1'b1, 3'd0);  // stale ack
        offer_word(FUNC_SEND,    32'h0F0F_F0F0, 3'd0, 1'b0, 3'd0);
        offer_word(FUNC_SEND,    32'h8000_0001, 3'd0, 1'b0, 3'd0);
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd4, 1'b1, 3'd0);
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd3, 1'b1, 3'd0);
        offer_word(FUNC_ACK,     32'h0000_0000, 3'd2, 1'b1, 3'd0);  // walks to 5
        offer_word(FUNC_EXPIRE,  32'h0000_0000, 3'd0, 1'b0, 3'd0);
        offer_word(FUNC_EXPIRE,  32'h0000_0000, 3'd0, 1'b0, 3'd2);

        for (phase = 0; phase < PHASES; phase++)
        begin
            settle();
            write_window_size(PHASE_SIZES[phase]);
            case (phase % 4)
                0:
                begin
                    sender_gap_pct     <= 0;
                    receiver_stall_pct <= 0;
                end
                1:
                begin
                    sender_gap_pct     <= 84;
                    receiver_stall_pct <= 0;
                end
                2:
                begin
                    sender_gap_pct     <= 0;
                    receiver_stall_pct <= 84;
                end
                default:
                begin
                    sender_gap_pct     <= 25;
                    receiver_stall_pct <= 25;
                end
            endcase
            // long receiver hold while words keep coming, so the queue backs up
            if (phase == 0)
                hold_asked <= hold_asked + 1;

            words_sent = 0;
            while (words_sent < RANDOM_WORDS / PHASES)
            begin
                roll   = $urandom_range(0, 99);
                ack_no = SEQ_BITS'($urandom);
                ack_ok = 1'($urandom);
                lapsed = SEQ_BITS'($urandom);
                case ($urandom_range(0, 9))
                    0:       word = '0;
                    1:       word = '1;
                    default: word = $urandom;
                endcase
                if (roll < 40)
                    func = FUNC_SEND;
                else if (roll < 80)
                begin
                    func = FUNC_ACK;
                    span = next_hint - base_hint;
                    if (span != 0 && $urandom_range(0, 99) < 85)
                    begin
                        ack_no = base_hint + SEQ_BITS'($urandom_range(0, span - 1));
                        ack_ok = ($urandom_range(0, 19) != 0);
                    end
                end
                else if (roll < 95 && written_hint != '0)
                begin
                    // only slots already holding a payload
                    func = FUNC_EXPIRE;
                    while (!written_hint[lapsed])
                        lapsed = SEQ_BITS'($urandom);
                end
                else if (roll < 95)
                    func = FUNC_SEND;
                else
                    func = FUNC_UNKNOWN;
                offer_word(func, word, ack_no, ack_ok, lapsed);
                if (func != FUNC_UNKNOWN)
                    words_sent++;
            end
        end

        settle();
        if (fail_count == 0)
            $display("selective_repeat_sender_window_unit_test OK");
        else
            $display("selective_repeat_sender_window_unit_test NOT OK");
        $finish;
    end

    initial
    begin : watchdog
        #5_000_000;
        $display("selective_repeat_sender_window_unit_test NOT OK");
        $finish;
    end

endmodule
